/* rtl/heat_jacobi_stencil_defines.svh */
// ----------------------------------------------------------------------------
// Heat Jacobi stencil assertion macros
// Shared property wrappers for the stencil RTL; they expect clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef HEAT_JACOBI_STENCIL_DEFINES_SVH
`define HEAT_JACOBI_STENCIL_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define HJS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hjs_pkg.sv */
// ----------------------------------------------------------------------------
// hjs_pkg
// Sizes, register codes, types and helpers for the heat Jacobi stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hjs_pkg;

  localparam int MAX_GRID   = 1024;
  localparam int MIN_GRID   = 3;
  localparam int TEMP_BITS  = 16;
  localparam int SIZE_W     = 11;                    // grid_size register width
  localparam int COL_W      = $clog2(MAX_GRID);      // column / line store address
  localparam int N_W        = $clog2(MAX_GRID + 2);  // grid size and row count (0..n+1)
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MEM_W      = 2 * TEMP_BITS + 1;     // {fire, upper row, middle row}

  typedef logic [TEMP_BITS-1:0] temp_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [N_W-1:0]       cnt_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_FIRE_LEVEL = 2'd1,
    REG_WALL_LEVEL = 2'd2
  } cfg_reg_t;

  // Classification of the cell that the current input position finishes.
  typedef struct packed {
    logic emit;       // a result is due for this beat
    logic border;     // finished cell sits on the grid border
    logic last;       // finished cell is the final one of the grid
    logic first_col;  // input position is in column zero
  } cell_info_t;

  // Clamp a written grid size into MIN_GRID..MAX_GRID.
  function automatic cnt_t clamp_size(input logic [SIZE_W-1:0] val);
    logic [SIZE_W+N_W-1:0] wide;
    wide = {{N_W{1'b0}}, val};
    if (wide < (SIZE_W+N_W)'(MIN_GRID)) begin
      return N_W'(MIN_GRID);
    end else if (wide > (SIZE_W+N_W)'(MAX_GRID)) begin
      return N_W'(MAX_GRID);
    end
    return wide[N_W-1:0];
  endfunction

endpackage

/* rtl/hjs_ram.sv */
// ----------------------------------------------------------------------------
// hjs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/hjs_pos.sv */
// ----------------------------------------------------------------------------
// hjs_pos
// Raster position counters and classification of the finished cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heat_jacobi_stencil_defines.svh"

module hjs_pos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               restart,
  input  hjs_pkg::cnt_t      grid_n,
  output hjs_pkg::col_t      col,
  output hjs_pkg::cell_info_t info
);
  import hjs_pkg::*;

  col_t col_r, col_nxt;
  cnt_t row_r, row_nxt;
  cnt_t n_plus1;
  cnt_t col_inc;
  cnt_t col_ext;

  assign n_plus1 = grid_n + N_W'(1);
  assign col_ext = N_W'(col_r);
  assign col_inc = col_ext + N_W'(1);

  always_comb begin
    info.first_col = (col_r == '0);
    info.emit      = (row_r >= N_W'(2)) || ((row_r == N_W'(1)) && !info.first_col);
    info.border    = info.first_col || (row_r == N_W'(1)) || (row_r >= grid_n) ||
                     (col_r == COL_W'(1));
    info.last      = info.first_col && (row_r == n_plus1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (row_r >= n_plus1) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= grid_n) begin
        col_nxt = '0;
        row_nxt = row_r + N_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end else begin
      // hold the position
      col_nxt = col_r;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

  `HJS_ASSERT_ALWAYS(a_col_in_grid, col_ext < grid_n, "column counter beyond grid size")
  `HJS_ASSERT_ALWAYS(a_row_in_flush, row_r <= n_plus1, "row counter beyond flush row")

endmodule

/* rtl/hjs_calc.sv */
// ----------------------------------------------------------------------------
// hjs_calc
// Five-point update: wall, fire or truncated mean of four neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hjs_calc (
  input  logic          border,
  input  logic          fire,
  input  hjs_pkg::temp_t wall_level,
  input  hjs_pkg::temp_t fire_level,
  input  hjs_pkg::temp_t up,
  input  hjs_pkg::temp_t down,
  input  hjs_pkg::temp_t left,
  input  hjs_pkg::temp_t right,
  output hjs_pkg::temp_t new_temp
);
  import hjs_pkg::*;

  logic [TEMP_BITS+1:0] sum;

  assign sum = (TEMP_BITS+2)'(up) + (TEMP_BITS+2)'(down) +
               (TEMP_BITS+2)'(left) + (TEMP_BITS+2)'(right);

  always_comb begin
    priority if (border) begin
      new_temp = wall_level;
    end else if (fire) begin
      new_temp = fire_level;
    end else begin
      new_temp = sum[TEMP_BITS+1:2];
    end
  end

endmodule

/* rtl/heat_jacobi_stencil.sv */
// ----------------------------------------------------------------------------
// heat_jacobi_stencil
// One Jacobi heat-diffusion step over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | in_cell_temp, in_is_fire, in_pad
//   out     | out_valid / out_ready | out_new_temp, out_last_cell
//   cfg     | cfg_we (no wait)      | cfg_addr, cfg_wdata
//
// One beat is accepted per cycle unless a stalled output holds an update stage
// that owes a result; a beat that owes no result leaves that stage without
// waiting for the output. A result is loaded into the output register as the
// update stage advances; the line store read data and the update share that
// stage. In stream order results lag by one row plus one cell. Reset clears
// control and window state; line store entries never written read as zero via
// a fill mark, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heat_jacobi_stencil_defines.svh"

module heat_jacobi_stencil (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hjs_pkg::TEMP_BITS-1:0]     in_cell_temp,
  input  logic                              in_is_fire,
  input  logic                              in_pad,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hjs_pkg::TEMP_BITS-1:0]     out_new_temp,
  output logic                              out_last_cell,
  // configuration
  input  logic                              cfg_we,
  input  logic [hjs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hjs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hjs_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cnt_t  grid_n_r;
  temp_t fire_level_r;
  temp_t wall_level_r;
  logic  grid_wr;

  always_comb begin
    grid_wr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GRID_SIZE:  grid_wr = 1'b1;
        REG_FIRE_LEVEL: grid_wr = 1'b0;
        REG_WALL_LEVEL: grid_wr = 1'b0;
        default:        grid_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_n_r     <= N_W'(MIN_GRID);
      fire_level_r <= '0;
      wall_level_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GRID_SIZE:  grid_n_r     <= clamp_size(cfg_wdata[SIZE_W-1:0]);
        REG_FIRE_LEVEL: fire_level_r <= cfg_wdata[TEMP_BITS-1:0];
        REG_WALL_LEVEL: wall_level_r <= cfg_wdata[TEMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic       in_acc;
  logic       s1_valid_r;
  logic       s1_adv;
  logic       out_load;
  cell_info_t s1_info_r;

  // Advance the update stage when its result has a free slot or it has none.
  assign s1_adv   = s1_valid_r && (!s1_info_r.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign out_load = s1_adv && s1_info_r.emit;

  // --------------------------------------------------------------------------
  // Stage 0: position, line store read
  // --------------------------------------------------------------------------
  col_t       col;
  cell_info_t info;

  hjs_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .restart (grid_wr),
    .grid_n  (grid_n_r),
    .col     (col),
    .info    (info)
  );

  // Line store entries are written in address order from zero, so the
  // written set is always a prefix; fill_r marks its end.
  cnt_t fill_r;
  logic rd_hit;

  assign rd_hit = (N_W'(col) < fill_r);

  temp_t s1_v_r;
  logic  s1_f_r;
  col_t  s1_addr_r;
  logic  s1_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Drop pad payloads to zero on entry.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_v_r    <= in_pad ? '0 : in_cell_temp;
      s1_f_r    <= !in_pad && in_is_fire;
      s1_addr_r <= col;
      s1_hit_r  <= rd_hit;
      s1_info_r <= info;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: {fire flag, upper row, middle row} per column
  // --------------------------------------------------------------------------
  logic [MEM_W-1:0] ram_rd_data;
  logic [MEM_W-1:0] ram_wr_data;
  logic [MEM_W-1:0] ram_q;

  assign ram_q = s1_hit_r ? ram_rd_data : '0;

  temp_t right;
  temp_t upc;
  logic  fr;

  assign right = ram_q[TEMP_BITS-1:0];
  assign upc   = ram_q[2*TEMP_BITS-1:TEMP_BITS];
  assign fr    = ram_q[MEM_W-1];

  // Shift the column down: middle becomes upper, the new cell becomes middle.
  assign ram_wr_data = {s1_f_r, right, s1_v_r};

  hjs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_GRID)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (ram_wr_data),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (ram_rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: window, update, state advance
  // --------------------------------------------------------------------------
  temp_t win_up_r;     // upper neighbor of the finished cell
  temp_t win_mid_r;    // center, next beat's left neighbor
  temp_t win_left_r;   // left neighbor of the finished cell
  logic  fire_dly_r;
  temp_t prev_v_r;     // last entered cell: lower neighbor
  temp_t down;
  temp_t new_temp;
  cnt_t  wr_end;

  assign down   = s1_info_r.first_col ? '0 : prev_v_r;
  assign wr_end = N_W'(s1_addr_r) + N_W'(1);

  hjs_calc u_calc (
    .border     (s1_info_r.border),
    .fire       (fire_dly_r),
    .wall_level (wall_level_r),
    .fire_level (fire_level_r),
    .up         (win_up_r),
    .down       (down),
    .left       (win_left_r),
    .right      (right),
    .new_temp   (new_temp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_up_r   <= '0;
      win_mid_r  <= '0;
      win_left_r <= '0;
      fire_dly_r <= 1'b0;
      prev_v_r   <= '0;
      fill_r     <= '0;
    end else if (s1_adv) begin
      win_left_r <= win_mid_r;
      win_mid_r  <= right;
      win_up_r   <= upc;
      fire_dly_r <= fr;
      prev_v_r   <= s1_v_r;
      if (wr_end > fill_r) begin
        fill_r <= wr_end;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic  out_valid_r;
  temp_t out_new_temp_r;
  logic  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_new_temp_r <= new_temp;
      out_last_r     <= s1_info_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_temp  = out_new_temp_r;
  assign out_last_cell = out_last_r;

  `HJS_ASSERT_NEXT(a_rd_hold, s1_valid_r && !s1_adv, $stable(ram_rd_data),
                   "line store read data moved under a held update stage")
  `HJS_ASSERT_NEXT(a_fill_mono, 1'b1, fill_r >= $past(fill_r),
                   "line store fill mark went backwards")

endmodule
